// ----- rtl/core/atpam_pkg.sv -----
// Package with the shared widths, codes and constants of the anti-tip PID arcade mixer.
package atpam_pkg;

	localparam int unsigned JOY_W   = 8;
	localparam int unsigned PITCH_W = 17;
	localparam int unsigned ILIM_W  = 23;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned MAXC_W  = 8;
	localparam int unsigned CORR_W  = 17;
	localparam int unsigned ERR_W   = 18;
	localparam int unsigned SUM_W   = 24;
	localparam int unsigned DIFF_W  = 19;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 23;
	localparam int unsigned DEPTH      = 5;

	localparam logic [MAXC_W-1:0] MAXC_RESET = 8'd127;
	localparam logic signed [10:0] SPEED_POS = 11'sd127;
	localparam logic signed [10:0] SPEED_NEG = -11'sd127;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_PITCH   = 3'd0,
		REG_INTEGRAL_LIMIT = 3'd1,
		REG_GAIN_P         = 3'd2,
		REG_GAIN_I         = 3'd3,
		REG_GAIN_D         = 3'd4,
		REG_MAX_CORRECTION = 3'd5
	} cfg_reg_t;

endpackage

// ----- rtl/core/anti_tip_pid_arcade_mixer.sv -----
// Anti-tip PID controller with a clamped integral, feeding an arcade drive mixer.
//
// Each beat on the input channel carries one control tick and produces exactly one beat
// on the output channel after it has passed every stage. One tick is accepted every cycle
// while the output is not stalled: the clamped error sum and the previous error are
// updated in the second stage for each tick, the three gain products are formed in
// parallel in the third, their sum is clamped in the fourth, and the correction and
// mixed speeds are registered in the fifth. A stall at the output holds every full stage
// behind it while empty stages still fill, so up to five beats wait inside before the
// input stalls. Configuration writes are taken in the cycle they are offered and must
// only be made while the block is empty.
module anti_tip_pid_arcade_mixer (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [atpam_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [atpam_pkg::CFG_DATA_W-1:0]             cfg_data,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic signed [atpam_pkg::JOY_W-1:0]           drive_forward,
	input  logic signed [atpam_pkg::JOY_W-1:0]           drive_turn,
	input  logic signed [atpam_pkg::PITCH_W-1:0]         pitch_meas,
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output logic signed [atpam_pkg::JOY_W-1:0]           left_speed,
	output logic signed [atpam_pkg::JOY_W-1:0]           right_speed,
	output logic signed [atpam_pkg::CORR_W-1:0]          correction
);

	logic signed [atpam_pkg::PITCH_W-1:0] target_pitch_q;
	logic        [atpam_pkg::ILIM_W-1:0]  integral_limit_q;
	logic signed [atpam_pkg::GAIN_W-1:0]  gain_p_q;
	logic signed [atpam_pkg::GAIN_W-1:0]  gain_i_q;
	logic signed [atpam_pkg::GAIN_W-1:0]  gain_d_q;
	logic        [atpam_pkg::MAXC_W-1:0]  max_correction_q;

	logic signed [atpam_pkg::SUM_W-1:0]   error_sum_q;
	logic signed [atpam_pkg::ERR_W-1:0]   prev_error_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic signed [atpam_pkg::JOY_W-1:0]   fwd_s1, turn_s1, fwd_s2, turn_s2;
	logic signed [atpam_pkg::JOY_W-1:0]   fwd_s3, turn_s3, fwd_s4, turn_s4;
	logic signed [atpam_pkg::PITCH_W-1:0] pitch_s1;
	logic signed [atpam_pkg::ERR_W-1:0]   err_s2;
	logic signed [atpam_pkg::SUM_W-1:0]   sum_s2;
	logic signed [atpam_pkg::DIFF_W-1:0]  diff_s2;
	logic signed [33:0]                   prod_p_s3;
	logic signed [39:0]                   prod_i_s3;
	logic signed [34:0]                   prod_d_s3;
	logic signed [24:0]                   s_s4;
	logic signed [atpam_pkg::JOY_W-1:0]   left_s5, right_s5;
	logic signed [atpam_pkg::CORR_W-1:0]  corr_s5;

	logic signed [atpam_pkg::ERR_W-1:0]   err;
	logic signed [24:0]                   sum_raw;
	logic signed [24:0]                   ilim;
	logic signed [atpam_pkg::SUM_W-1:0]   sum_new;
	logic signed [atpam_pkg::DIFF_W-1:0]  diff;
	logic signed [33:0]                   prod_p;
	logic signed [39:0]                   prod_i;
	logic signed [34:0]                   prod_d;
	logic signed [41:0]                   s_total;
	logic signed [41:0]                   clim;
	logic signed [24:0]                   s_clamped;
	logic signed [24:0]                   corr_full;
	logic signed [25:0]                   fwd_diff;
	logic signed [25:0]                   fwd_round;
	logic signed [9:0]                    f_val;
	logic signed [10:0]                   left_raw, right_raw;
	logic signed [atpam_pkg::JOY_W-1:0]   left_sat, right_sat;

	// Ready travels back through the stages so that a new beat enters whenever space frees up.
	assign rdy_s5 = !v_s5 || out_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign in_ready  = rdy_s1;
	assign cfg_ready = 1'b1;
	assign out_valid = v_s5;
	assign left_speed  = left_s5;
	assign right_speed = right_s5;
	assign correction  = corr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_pitch_q   <= '0;
			integral_limit_q <= '0;
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			max_correction_q <= atpam_pkg::MAXC_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				atpam_pkg::REG_TARGET_PITCH: begin
					target_pitch_q <= signed'(cfg_data[atpam_pkg::PITCH_W-1:0]);
				end
				atpam_pkg::REG_INTEGRAL_LIMIT: begin
					integral_limit_q <= cfg_data[atpam_pkg::ILIM_W-1:0];
				end
				atpam_pkg::REG_GAIN_P: begin
					gain_p_q <= signed'(cfg_data[atpam_pkg::GAIN_W-1:0]);
				end
				atpam_pkg::REG_GAIN_I: begin
					gain_i_q <= signed'(cfg_data[atpam_pkg::GAIN_W-1:0]);
				end
				atpam_pkg::REG_GAIN_D: begin
					gain_d_q <= signed'(cfg_data[atpam_pkg::GAIN_W-1:0]);
				end
				atpam_pkg::REG_MAX_CORRECTION: begin
					max_correction_q <= cfg_data[atpam_pkg::MAXC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Error, clamped running sum and first difference.
	always_comb begin
		err     = atpam_pkg::ERR_W'(target_pitch_q) - atpam_pkg::ERR_W'(pitch_s1);
		sum_raw = 25'(error_sum_q) + 25'(err);
		ilim    = signed'({2'b00, integral_limit_q});
		if (sum_raw > ilim) begin
			sum_new = atpam_pkg::SUM_W'(ilim);
		end else if (sum_raw < -ilim) begin
			sum_new = atpam_pkg::SUM_W'(-ilim);
		end else begin
			sum_new = atpam_pkg::SUM_W'(sum_raw);
		end
		diff = atpam_pkg::DIFF_W'(err) - atpam_pkg::DIFF_W'(prev_error_q);
	end

	always_comb begin
		prod_p = 34'(gain_p_q) * 34'(err_s2);
		prod_i = 40'(gain_i_q) * 40'(sum_s2);
		prod_d = 35'(gain_d_q) * 35'(diff_s2);
	end

	always_comb begin
		s_total = 42'(prod_p_s3) + 42'(prod_i_s3) + 42'(prod_d_s3);
		clim    = signed'({18'd0, max_correction_q, 16'd0});
		if (s_total > clim) begin
			s_clamped = 25'(clim);
		end else if (s_total < -clim) begin
			s_clamped = 25'(-clim);
		end else begin
			s_clamped = 25'(s_total);
		end
	end

	// Divisions truncate toward zero, so negative values are biased before the shift.
	always_comb begin
		corr_full = s_s4 + (s_s4[24] ? 25'sd255 : 25'sd0);
		fwd_diff  = signed'({{2{fwd_s4[7]}}, fwd_s4, 16'd0}) - 26'(s_s4);
		fwd_round = fwd_diff + (fwd_diff[25] ? 26'sd65535 : 26'sd0);
		f_val     = 10'(fwd_round >>> 16);
		left_raw  = 11'(f_val) - 11'(turn_s4);
		right_raw = 11'(f_val) + 11'(turn_s4);
		if (left_raw > atpam_pkg::SPEED_POS) begin
			left_sat = atpam_pkg::JOY_W'(atpam_pkg::SPEED_POS);
		end else if (left_raw < atpam_pkg::SPEED_NEG) begin
			left_sat = atpam_pkg::JOY_W'(atpam_pkg::SPEED_NEG);
		end else begin
			left_sat = atpam_pkg::JOY_W'(left_raw);
		end
		if (right_raw > atpam_pkg::SPEED_POS) begin
			right_sat = atpam_pkg::JOY_W'(atpam_pkg::SPEED_POS);
		end else if (right_raw < atpam_pkg::SPEED_NEG) begin
			right_sat = atpam_pkg::JOY_W'(atpam_pkg::SPEED_NEG);
		end else begin
			right_sat = atpam_pkg::JOY_W'(right_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			error_sum_q  <= '0;
			prev_error_q <= '0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
			if (v_s1 && rdy_s2) begin
				error_sum_q  <= sum_new;
				prev_error_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			fwd_s1   <= drive_forward;
			turn_s1  <= drive_turn;
			pitch_s1 <= pitch_meas;
		end
		if (rdy_s2 && v_s1) begin
			fwd_s2  <= fwd_s1;
			turn_s2 <= turn_s1;
			err_s2  <= err;
			sum_s2  <= sum_new;
			diff_s2 <= diff;
		end
		if (rdy_s3 && v_s2) begin
			fwd_s3    <= fwd_s2;
			turn_s3   <= turn_s2;
			prod_p_s3 <= prod_p;
			prod_i_s3 <= prod_i;
			prod_d_s3 <= prod_d;
		end
		if (rdy_s4 && v_s3) begin
			fwd_s4  <= fwd_s3;
			turn_s4 <= turn_s3;
			s_s4    <= s_clamped;
		end
		if (rdy_s5 && v_s4) begin
			left_s5  <= left_sat;
			right_s5 <= right_sat;
			corr_s5  <= atpam_pkg::CORR_W'(corr_full >>> 8);
		end
	end

endmodule

// ----- rtl/core/atpam_checker.sv -----
// Port-level checker for the anti-tip PID arcade mixer and its bind statement.
module atpam_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic [atpam_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [atpam_pkg::CFG_DATA_W-1:0]     cfg_data,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic signed [atpam_pkg::JOY_W-1:0]   drive_forward,
	input logic signed [atpam_pkg::JOY_W-1:0]   drive_turn,
	input logic signed [atpam_pkg::PITCH_W-1:0] pitch_meas,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [atpam_pkg::JOY_W-1:0]   left_speed,
	input logic signed [atpam_pkg::JOY_W-1:0]   right_speed,
	input logic signed [atpam_pkg::CORR_W-1:0]  correction
);

	logic [2:0] pending_q;
	logic       in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_speed)
			&& $stable(right_speed) && $stable(correction))
		else $error("Stalled output beat changed or dropped.");

	a_out_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("Output beat without an accepted input beat.");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'(atpam_pkg::DEPTH))
		else $error("More beats in flight than pipeline stages.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("Input stalled while the output is not blocked.");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_speed != -8'sd128 && right_speed != -8'sd128)
		else $error("Motor command outside the saturation range.");

endmodule

bind anti_tip_pid_arcade_mixer atpam_checker u_atpam_checker (.*);
